// ===== rtl/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the alphabet lookup for the Base64 encoder.
// Used by every module under rtl/; depends on nothing.
package b64e_pkg;

  localparam int unsigned LINE_THRESHOLD_DEF = 72;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  localparam logic [6:0] CH_PAD    = 7'd61;
  localparam logic [6:0] CH_CR     = 7'd13;
  localparam logic [6:0] CH_LF     = 7'd10;
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // One encode request from the front to the back.
  typedef struct packed {
    logic [23:0] group;      // three bytes, first in bits 23..16
    logic [1:0]  pad_count;  // trailing '=' characters (0..2)
    logic        crlf;       // append CR LF after the group
    logic        eom;        // group closes the message
  } job_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [6:0] sym(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd26)      sym = w + 7'd65;
    else if (v < 6'd52) sym = w + 7'd71;   // 'a' - 26
    else if (v < 6'd62) sym = w - 7'd4;    // '0' - 52
    else if (v == 6'd62) sym = 7'd43;      // '+'
    else                 sym = 7'd47;      // '/'
  endfunction

endpackage

// ===== rtl/b64e_if.sv =====
// b64e_if: valid/ready channel interfaces for the byte input and the character output.
// No dependencies.
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;
  logic       message_done;

  modport source (output valid, out_char, last_of_run, message_done, input ready);
  modport sink   (input valid, out_char, last_of_run, message_done, output ready);
endinterface

// ===== rtl/base64_stream_encoder.sv =====
// base64_stream_encoder: streaming Base64 encoder top level (front, request queue, back).
// Depends on b64e_pkg, b64e_if, b64e_front, b64e_queue and b64e_back.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    data_byte[7:0], end_of_message
//   out_ch    out  valid/ready    out_char[6:0], last_of_run, message_done
//   cfg       in   cfg_we only    cfg_wdata = line_breaks
//
// A byte is taken whenever in_ch.ready is high; a completed or final group becomes a
// request in the queue, and the back drains it at one character per cycle while out_ch
// is ready, so a group gives 4 characters (6 with CR LF) and sustained input is held to
// the output character rate. The byte that closes a group is written into the queue, and
// its first character then goes through the output register. Reset clears phase, held
// bytes, line count, the queue and the output valid flag. in_ch stalls only while the
// queue is full; out_ch stalls hold the output register and back up into the queue.
module base64_stream_encoder #(
  parameter int unsigned LINE_THRESHOLD = b64e_pkg::LINE_THRESHOLD_DEF,
  parameter int unsigned QUEUE_DEPTH    = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  b64e_byte_if.sink     in_ch,
  b64e_char_if.source   out_ch
);

  logic           line_breaks;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;
  b64e_pkg::job_t push_job;
  b64e_pkg::job_t head_job;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // Hold the line-break enable; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      line_breaks <= 1'b0;
    end else if (cfg_we) begin
      line_breaks <= cfg_wdata;
    end
  end

  // Front: take bytes, keep group and line state, issue requests.
  b64e_front #(
    .LINE_THRESHOLD(LINE_THRESHOLD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .line_breaks(line_breaks),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Queue: decouple byte intake from character output.
  b64e_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (head_job),
    .count    (q_count)
  );

  // Back: emit characters, advance through each request, drop it when done.
  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_not_empty),
    .job      (head_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.message_done |-> out_ch.last_of_run)
    else $error("message_done without last_of_run");

  a_cr_not_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.out_char == b64e_pkg::CH_CR) |-> !out_ch.last_of_run)
    else $error("CR ended a run");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && (out_ch.out_char == b64e_pkg::CH_CR)
      |=> out_ch.valid && (out_ch.out_char == b64e_pkg::CH_LF))
    else $error("CR not followed by LF");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) && !(push && q_full && !pop))
    else $error("request queue overflow");

endmodule

// ===== rtl/b64e_front.sv =====
// b64e_front: accepts bytes, gathers groups, tracks line length and issues encode requests.
// Depends on b64e_pkg and b64e_if.
module b64e_front #(
  parameter int unsigned LINE_THRESHOLD = b64e_pkg::LINE_THRESHOLD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             line_breaks,
  b64e_byte_if.sink        in_ch,
  input  logic             q_full,
  output logic             push,
  output b64e_pkg::job_t   push_job
);

  logic [1:0]  group_phase;
  logic [15:0] held_bytes;
  logic [6:0]  line_count;

  logic [1:0]  phase;
  logic        accept;
  logic [7:0]  lc_sum;
  logic [6:0]  lc_sat;
  logic        crlf;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign phase       = (group_phase == 2'd3) ? 2'd0 : group_phase;

  assign lc_sum = {1'b0, line_count} + 8'd4;
  assign lc_sat = lc_sum[7] ? b64e_pkg::COUNT_MAX : lc_sum[6:0];
  assign crlf   = line_breaks && (lc_sat > 7'(LINE_THRESHOLD));

  assign push = accept && ((phase == 2'd2) || in_ch.end_of_message);

  always_comb begin
    push_job.eom = in_ch.end_of_message;
    case (phase)
      2'd2: begin
        push_job.group     = {held_bytes, in_ch.data_byte};
        push_job.pad_count = 2'd0;
        push_job.crlf      = crlf;
      end
      2'd1: begin
        push_job.group     = {held_bytes[15:8], in_ch.data_byte, 8'h00};
        push_job.pad_count = 2'd1;
        push_job.crlf      = 1'b0;
      end
      default: begin
        push_job.group     = {in_ch.data_byte, 16'h0000};
        push_job.pad_count = 2'd2;
        push_job.crlf      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= 2'd0;
      held_bytes  <= 16'h0000;
      line_count  <= 7'd0;
    end else if (accept) begin
      if (in_ch.end_of_message) begin
        group_phase <= 2'd0;
        held_bytes  <= 16'h0000;
        line_count  <= 7'd0;
      end else if (phase == 2'd2) begin
        group_phase <= 2'd0;
        held_bytes  <= 16'h0000;
        line_count  <= crlf ? 7'd0 : lc_sat;
      end else if (phase == 2'd1) begin
        group_phase <= 2'd2;
        held_bytes  <= {held_bytes[15:8], in_ch.data_byte};
      end else begin
        group_phase <= 2'd1;
        held_bytes  <= {in_ch.data_byte, 8'h00};
      end
    end
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// b64e_queue: small FIFO of encode requests between front and back.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64e_pkg::job_t   push_job,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output b64e_pkg::job_t   head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = $clog2(DEPTH);

  b64e_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;

  assign full      = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// b64e_back: walks one encode request into 4 or 6 characters, one per cycle while out_ch
// is not stalled, into an output register. Depends on b64e_pkg and b64e_if.
module b64e_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  b64e_pkg::job_t   job,
  output logic             pop,
  b64e_char_if.source      out_ch
);

  logic [2:0] idx;
  logic       advance;
  logic       take;
  logic       last_char;
  logic [6:0] ch;
  logic [5:0] sextet;
  logic       padded;

  assign advance   = !out_ch.valid || out_ch.ready;
  assign take      = job_valid && advance;
  assign last_char = job.crlf ? (idx == 3'd5) : (idx == 3'd3);
  assign pop       = take && last_char;

  always_comb begin
    sextet = job.group[23:18];
    padded = 1'b0;
    case (idx)
      3'd0: sextet = job.group[23:18];
      3'd1: sextet = job.group[17:12];
      3'd2: begin
        sextet = job.group[11:6];
        padded = (job.pad_count >= 2'd2);
      end
      3'd3: begin
        sextet = job.group[5:0];
        padded = (job.pad_count >= 2'd1);
      end
      default: sextet = job.group[23:18];
    endcase
    case (idx)
      3'd4:    ch = b64e_pkg::CH_CR;
      3'd5:    ch = b64e_pkg::CH_LF;
      default: ch = padded ? b64e_pkg::CH_PAD : b64e_pkg::sym(sextet);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= 3'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (advance) begin
        out_ch.valid <= job_valid;
      end
      if (take) begin
        idx <= last_char ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.out_char     <= ch;
      out_ch.last_of_run  <= last_char;
      out_ch.message_done <= last_char && job.eom;
    end
  end

endmodule
